// ----- hdl/msc_pkg.sv -----
package msc_pkg;

    localparam int WINDOW_SIZE = 5;
    localparam int MEDIAN_POS  = WINDOW_SIZE / 2;
    localparam int SLOT_W      = $clog2(WINDOW_SIZE);
    localparam int RANK_W      = $clog2(WINDOW_SIZE + 1);

    localparam int SPEED_W     = 7;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SPEED_W-1:0] SPEED_CAP_RST      = 7'd80;
    localparam logic [SPEED_W-1:0] RAMP_STEP_RST      = 7'd5;
    localparam logic [SPEED_W-1:0] OVERLOAD_LEVEL_RST = 7'd75;
    localparam logic [TIME_W-1:0]  OVERLOAD_TIME_RST  = 32'd3000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_CAP      = 2'd0,
        REG_RAMP_STEP      = 2'd1,
        REG_OVERLOAD_LEVEL = 2'd2,
        REG_OVERLOAD_TIME  = 2'd3
    } t_cfg_idx;

    typedef logic [WINDOW_SIZE-1:0][SPEED_W-1:0] t_window;

    typedef struct packed {
        logic [SPEED_W-1:0] target_speed;
        logic               forward;
        logic [TIME_W-1:0]  time_ms;
    } t_in_item;

    typedef struct packed {
        logic [SPEED_W-1:0] capped_speed;
        logic [SPEED_W-1:0] filtered_speed;
        logic [SPEED_W-1:0] drive_speed;
        logic               drive_direction;
        logic               drive_enable;
        logic               overload_alert;
        logic [COUNT_W-1:0] overload_total;
    } t_out_item;

endpackage

// ----- hdl/motor_speed_conditioner.sv -----
// A transaction accepted on the input passes two register stages, input and
//   result. Throughput: one transaction per cycle unless the output stalls;
//   clamp, five-entry median, ramp and the overload timer all resolve between
//   the input and the result register.
// Reset (synchronous, active low): sample window, slot, drive level, overload
//   state and counters clear; configuration returns to its default values.
module motor_speed_conditioner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  msc_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output msc_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import msc_pkg::*;

    // configuration
    logic [SPEED_W-1:0] r_speed_cap;
    logic [SPEED_W-1:0] r_ramp_step;
    logic [SPEED_W-1:0] r_ovl_level;
    logic [TIME_W-1:0]  r_ovl_time;

    // pipeline
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      advance;

    // conditioning state
    t_window            r_window, n_window;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [SPEED_W-1:0] r_level, n_level;
    logic               r_over_active, n_over_active;
    logic               r_alert, n_alert;
    logic [COUNT_W-1:0] r_alert_count, n_alert_count;
    logic [TIME_W-1:0]  r_over_start, n_over_start;

    logic [SPEED_W-1:0] capped;
    logic [SPEED_W-1:0] median;
    logic [SPEED_W-1:0] up_gap;
    logic [SPEED_W-1:0] dn_gap;
    logic [TIME_W-1:0]  elapsed;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_cap <= SPEED_CAP_RST;
            r_ramp_step <= RAMP_STEP_RST;
            r_ovl_level <= OVERLOAD_LEVEL_RST;
            r_ovl_time  <= OVERLOAD_TIME_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_SPEED_CAP:      r_speed_cap <= i_cfg_data[SPEED_W-1:0];
                REG_RAMP_STEP:      r_ramp_step <= i_cfg_data[SPEED_W-1:0];
                REG_OVERLOAD_LEVEL: r_ovl_level <= i_cfg_data[SPEED_W-1:0];
                REG_OVERLOAD_TIME:  r_ovl_time  <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp and write the new sample into its slot
    assign capped = (r_in.target_speed > r_speed_cap) ? r_speed_cap : r_in.target_speed;

    always_comb begin
        for (int k = 0; k < WINDOW_SIZE; k++) begin
            n_window[k] = (SLOT_W'(k) == r_slot) ? capped : r_window[k];
        end
    end

    assign n_slot = (r_slot == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : r_slot + 1'b1;

    msc_median u_median (
        .i_window (n_window),
        .o_median (median)
    );

    assign up_gap  = median - r_level;
    assign dn_gap  = r_level - median;
    assign elapsed = r_in.time_ms - r_over_start;

    always_comb begin
        n_level       = r_level;
        n_over_active = r_over_active;
        n_alert       = r_alert;
        n_alert_count = r_alert_count;
        n_over_start  = r_over_start;

        // step toward the median, never past it
        if (r_level < median) begin
            n_level = r_level + ((up_gap > r_ramp_step) ? r_ramp_step : up_gap);
        end else if (r_level > median) begin
            n_level = r_level - ((dn_gap > r_ramp_step) ? r_ramp_step : dn_gap);
        end

        if (n_level >= r_ovl_level) begin
            if (!r_over_active) begin
                n_over_active = 1'b1;
                n_over_start  = r_in.time_ms;
            end else if (elapsed > r_ovl_time && !r_alert) begin
                n_alert       = 1'b1;
                n_alert_count = r_alert_count + 1'b1;
            end
        end else begin
            n_over_active = 1'b0;
            n_alert       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_window      <= '0;
            r_slot        <= '0;
            r_level       <= '0;
            r_over_active <= 1'b0;
            r_alert       <= 1'b0;
            r_alert_count <= '0;
            r_over_start  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld     <= 1'b1;
                r_window      <= n_window;
                r_slot        <= n_slot;
                r_level       <= n_level;
                r_over_active <= n_over_active;
                r_alert       <= n_alert;
                r_alert_count <= n_alert_count;
                r_over_start  <= n_over_start;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out.capped_speed    <= capped;
            r_out.filtered_speed  <= median;
            r_out.drive_speed     <= n_level;
            r_out.drive_direction <= r_in.forward;
            r_out.drive_enable    <= (n_level != '0);
            r_out.overload_alert  <= n_alert;
            r_out.overload_total  <= n_alert_count;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // the alert latch only stands while overload timing runs
    a_alert_needs_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alert |-> r_over_active)
        else $error("alert latched without overload timing");

    // the counter moves only when the alert rises
    a_count_on_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_alert_count != $past(r_alert_count)))
            |-> (r_alert && !$past(r_alert)))
        else $error("alert count changed without a new alert");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(WINDOW_SIZE - 1))
        else $error("write slot out of range");

    // a held result is not overwritten while the consumer stalls
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

// ----- hdl/msc_median.sv -----
module msc_median (
    input  msc_pkg::t_window                i_window,
    output logic [msc_pkg::SPEED_W-1:0]     o_median
);
    import msc_pkg::*;

    logic [WINDOW_SIZE-1:0] hit;

    // An entry is the median when at most MEDIAN_POS entries sort below it
    // and more than MEDIAN_POS sort at or below it.
    for (genvar gi = 0; gi < WINDOW_SIZE; gi++) begin : g_rank
        logic [RANK_W-1:0] lt_cnt;
        logic [RANK_W-1:0] le_cnt;

        always_comb begin
            lt_cnt = '0;
            le_cnt = '0;
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                lt_cnt = lt_cnt + RANK_W'(i_window[j] <  i_window[gi]);
                le_cnt = le_cnt + RANK_W'(i_window[j] <= i_window[gi]);
            end
        end

        assign hit[gi] = (lt_cnt <= RANK_W'(MEDIAN_POS)) && (le_cnt > RANK_W'(MEDIAN_POS));
    end

    // Equal entries that qualify carry the same value; take the lowest index.
    always_comb begin
        o_median = '0;
        for (int i = WINDOW_SIZE - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_median = i_window[i];
            end
        end
    end

endmodule
